// ===== design/dhi_pkg.sv =====
// ----------------------------------------------------------------------------
// dhi_pkg: shared types and constants for the d-ary heap insert unit
// Holds sizes, status and command codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package dhi_pkg;
  localparam int Capacity = 1024;
  localparam int AddrBits = $clog2(Capacity);
  localparam int CountBits = AddrBits + 1;
  localparam int KeyBits = 64;
  localparam int TagBits = 16;
  localparam int MaxArity = 8;
  localparam int ArityBits = 4;
  localparam int EntryBits = KeyBits + TagBits;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusLocked = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdClear = 1'b1;

  localparam logic [1:0] RegArity = 2'd0;
  localparam logic [1:0] RegOrder = 2'd1;
  localparam logic [1:0] RegLocked = 2'd2;

  typedef struct packed {
    logic load;       // capture input word, start at fill position
    logic write_new;  // write new entry at current position
    logic read_par;   // read the parent of the current position
    logic move_down;  // write parent entry at position, step up
    logic read_root;  // read entry 0
    logic clear;      // empty the heap
  } dhi_cmd_t;

  typedef struct packed {
    logic at_root;  // current position is 0
    logic rise;     // new key should pass its parent
    logic full;
    logic empty;
  } dhi_stat_t;
endpackage

// ===== design/dhi_ram.sv =====
// ----------------------------------------------------------------------------
// dhi_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module dhi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/dhi_datapath.sv =====
// ----------------------------------------------------------------------------
// dhi_datapath: heap storage, position tracking and key compare
// Holds the entry RAM, the fill count, the sift position and its parent.
// ----------------------------------------------------------------------------
module dhi_datapath import dhi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dhi_cmd_t             cmd,
  input  logic [ArityBits-1:0] arity,
  input  logic                 order_mode,
  input  logic [KeyBits-1:0]   key,
  input  logic [TagBits-1:0]   tag,
  output dhi_stat_t            stat,
  output logic [CountBits-1:0] entry_count,
  output logic [KeyBits-1:0]   root_key,
  output logic [TagBits-1:0]   root_tag
);
  logic [CountBits-1:0] fill_count;
  logic [AddrBits-1:0]  pos;
  logic [AddrBits-1:0]  parent;
  logic [AddrBits-1:0]  parent_next;
  logic [KeyBits-1:0]   new_key;
  logic [TagBits-1:0]   new_tag;
  logic [EntryBits-1:0] parent_entry;
  logic [AddrBits-1:0]  ram_addr;
  logic                 ram_we;
  logic [EntryBits-1:0] ram_wdata;
  logic [EntryBits-1:0] ram_rdata;
  logic [AddrBits-1:0]  pm1;
  logic [ArityBits-1:0] d;
  logic [KeyBits-1:0]   par_key;

  // Parent index (pos-1)/d for d in 2..8, by a shift or a reciprocal multiply.
  always_comb begin
    if (arity < ArityBits'(2)) begin
      d = ArityBits'(2);
    end else if (arity > ArityBits'(MaxArity)) begin
      d = ArityBits'(MaxArity);
    end else begin
      d = arity;
    end
    pm1 = pos - AddrBits'(1);
    case (d)
      4'd2:    parent_next = AddrBits'(pm1 >> 1);
      4'd3:    parent_next = AddrBits'((22'(pm1) * 22'd1366) >> 12);
      4'd4:    parent_next = AddrBits'(pm1 >> 2);
      4'd5:    parent_next = AddrBits'((22'(pm1) * 22'd1639) >> 13);
      4'd6:    parent_next = AddrBits'((22'(pm1) * 22'd1366) >> 13);
      4'd7:    parent_next = AddrBits'((22'(pm1) * 22'd2341) >> 14);
      default: parent_next = AddrBits'(pm1 >> 3);
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = pos;
    ram_wdata = {new_key, new_tag};
    if (cmd.write_new) begin
      ram_we = 1'b1;
    end else if (cmd.move_down) begin
      ram_we = 1'b1;
      ram_wdata = parent_entry;
    end else if (cmd.read_par) begin
      ram_addr = parent;
    end else if (cmd.read_root) begin
      ram_addr = '0;
    end
    if (cmd.read_par || cmd.read_root) begin
      ram_we = 1'b0;
    end
  end

  dhi_ram #(.Width(EntryBits), .Depth(Capacity)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.clear) begin
      fill_count <= '0;
    end else if (cmd.load) begin
      fill_count <= fill_count + CountBits'(1);
    end
    if (cmd.load) begin
      pos <= AddrBits'(fill_count);
      new_key <= key;
      new_tag <= tag;
    end
    if (cmd.read_par) begin
      parent <= parent;
    end else begin
      parent <= parent_next;
    end
    if (cmd.move_down) begin
      pos <= parent;
    end
  end

  assign parent_entry = ram_rdata;
  assign par_key = ram_rdata[EntryBits-1 -: KeyBits];
  assign stat.at_root = (pos == '0);
  assign stat.rise = order_mode ? (new_key <= par_key) : (new_key >= par_key);
  assign stat.full = (fill_count >= CountBits'(Capacity));
  assign stat.empty = (fill_count == '0);
  assign entry_count = fill_count;
  assign root_key = ram_rdata[EntryBits-1 -: KeyBits];
  assign root_tag = ram_rdata[TagBits-1:0];
endmodule

// ===== design/dhi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhi_ctrl: sequencer for insert, sift-up and result delivery
// Walks one word through its steps and holds the result register.
// ----------------------------------------------------------------------------
module dhi_ctrl import dhi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic                 locked,
  input  dhi_stat_t            stat,
  input  logic [CountBits-1:0] entry_count,
  input  logic [KeyBits-1:0]   root_key,
  input  logic [TagBits-1:0]   root_tag,
  output dhi_cmd_t             cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [CountBits-1:0] out_count,
  output logic [KeyBits-1:0]   top_key,
  output logic [TagBits-1:0]   top_tag
);
  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_PARENT, S_READ, S_DECIDE, S_ROOT, S_ROOTWAIT, S_DONE
  } state_t;

  state_t state;
  logic   res_pending;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_cmd == CmdClear) begin
            cmd.clear = 1'b1;
          end else if (!locked && !stat.full) begin
            cmd.load = 1'b1;
          end
        end
      end
      S_WRITE:    cmd.write_new = 1'b1;
      S_READ:     cmd.read_par = 1'b1;
      S_DECIDE:   cmd.move_down = !stat.at_root && stat.rise;
      S_ROOT:     cmd.read_root = 1'b1;
      S_ROOTWAIT: cmd.read_root = 1'b1;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      res_pending <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_cmd == CmdClear) begin
              status <= StatusOk;
              state <= S_DONE;
            end else if (locked) begin
              status <= StatusLocked;
              state <= S_ROOT;
            end else if (stat.full) begin
              status <= StatusFull;
              state <= S_ROOT;
            end else begin
              status <= StatusOk;
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: state <= S_PARENT;
        S_PARENT: begin
          if (stat.at_root) begin
            state <= S_ROOT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ:   state <= S_DECIDE;
        S_DECIDE: begin
          if (stat.rise) begin
            state <= S_WRITE;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT:     state <= S_ROOTWAIT;
        S_ROOTWAIT: state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          out_count <= entry_count;
          top_key <= stat.empty ? '0 : root_key;
          top_tag <= stat.empty ? '0 : root_tag;
          res_pending <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE && in_valid && in_ready) begin
        res_pending <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      assert (!(out_valid && res_pending && state == S_IDLE))
        else $error("result pending while idle");
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result not raised");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

// ===== design/dary_heap_insert_unit.sv =====
// ----------------------------------------------------------------------------
// dary_heap_insert_unit: d-ary heap insert with max or min order
// Inserts key/tag words into a RAM heap, sifts up, and reports the root.
// ----------------------------------------------------------------------------
// Channel  Signals                              Moves
// in       in_valid/in_ready cmd key tag        one command word
// out      out_valid/out_ready status ...       one result word
// cfg      cfg_valid/cfg_ready cfg_index cfg_data  one register write
//
// An insert writes the new entry, then at each level reads the parent and, if
// the new key should pass it, moves the parent down and writes the new entry
// one level up; it then reads the root for the result, one access at a time
// on the single-port RAM. Locked or full inserts only read the root; a clear
// skips it. One word is in work at a time, and no new word is taken while a
// result waits for out_ready. Reset empties the heap; RAM needs no clearing.
// ----------------------------------------------------------------------------
module dary_heap_insert_unit import dhi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [KeyBits-1:0]   key,
  input  logic [TagBits-1:0]   tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [CountBits-1:0] entry_count,
  output logic [KeyBits-1:0]   top_key,
  output logic [TagBits-1:0]   top_tag,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [ArityBits-1:0] cfg_data
);
  logic [ArityBits-1:0] arity;
  logic                 order_mode;
  logic                 locked;
  dhi_cmd_t             dp_cmd;
  dhi_stat_t            dp_stat;
  logic [CountBits-1:0] fill;
  logic [KeyBits-1:0]   root_key;
  logic [TagBits-1:0]   root_tag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      arity <= ArityBits'(2);
      order_mode <= 1'b0;
      locked <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegArity:  arity <= cfg_data;
        RegOrder:  order_mode <= cfg_data[0];
        RegLocked: locked <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  dhi_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .arity       (arity),
    .order_mode  (order_mode),
    .key         (key),
    .tag         (tag),
    .stat        (dp_stat),
    .entry_count (fill),
    .root_key    (root_key),
    .root_tag    (root_tag)
  );

  dhi_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (cmd),
    .locked      (locked),
    .stat        (dp_stat),
    .entry_count (fill),
    .root_key    (root_key),
    .root_tag    (root_tag),
    .cmd         (dp_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_count   (entry_count),
    .top_key     (top_key),
    .top_tag     (top_tag)
  );
endmodule
